### sv/spq_pkg.sv
// Shared constants and types for the sorted-insert priority queue.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic signed [DATA_W-1:0] t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry value;
    } t_cell_cmd;

endpackage
`default_nettype wire

### sv/spq_cell.sv
// One storage cell of the descending chain: holds an entry and its valid bit.
`default_nettype none
module spq_cell import spq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_cmd i_cmd,
    input  wire t_entry    i_prev_entry,
    input  wire logic      i_prev_valid,
    input  wire logic      i_prev_keep,
    input  wire t_entry    i_next_entry,
    input  wire logic      i_next_valid,
    output t_entry         o_entry,
    output logic           o_valid,
    output logic           o_keep
);

    t_entry r_entry;
    logic   r_valid;
    t_entry n_entry;
    logic   n_valid;

    // Keep own entry on push when it is not smaller than the new value.
    assign o_keep = r_valid && (r_entry >= i_cmd.value);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.push) begin
            n_valid = r_valid | i_prev_valid;
            if (!o_keep) begin
                n_entry = i_prev_keep ? i_cmd.value : i_prev_entry;
            end
        end else if (i_cmd.pop) begin
            // Advance toward the head.
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

### sv/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: cell chain, count and result register.
`default_nettype none
// The queue holds up to CAPACITY signed 32-bit values in a row of cells kept in
// descending order, so the largest value always sits in cell 0. A push (opcode 0)
// is broadcast to all cells at once: each cell compares its entry with the new
// value and either holds, takes the new value, or takes its left neighbor's entry,
// which opens a gap at the insertion point. A pop (opcode 1)
// returns cell 0 and shifts every cell one place toward the head. Each operation
// produces exactly one result, registered at the output; a new
// item is accepted in every cycle in which the result register is empty or being
// taken, so the sustained rate is one item per cycle, bounded by the cell compare.
// A pop of an empty queue returns 0 with o_empty_pop set; a push to a full queue
// is dropped with o_push_dropped set. o_entry_count reports the count afterwards,
// modulo 32. No clearing pass is needed after reset.
module sorted_insert_priority_queue import spq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_opcode,
    input  wire logic signed [31:0] i_data_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_popped_value,
    output logic [4:0]              o_entry_count,
    output logic                    o_empty_pop,
    output logic                    o_push_dropped
);

    t_entry             w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_keep;
    t_cell_cmd          w_cmd;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_entry             r_popped;
    logic               r_empty_pop;
    logic               r_push_dropped;
    logic [COUNT_W-1:0] r_entry_count;

    logic               w_xfer;
    logic               w_full;
    logic               w_empty;

    // Take a new item whenever the result register is free or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_xfer     = i_in_valid && o_in_ready;

    assign w_full  = w_valid[CAPACITY-1];
    assign w_empty = !w_valid[0];

    // Drop pushes to a full queue and pops of an empty one before they reach the cells.
    assign w_cmd.push  = w_xfer && (i_opcode == OP_PUSH) && !w_full;
    assign w_cmd.pop   = w_xfer && (i_opcode == OP_POP) && !w_empty;
    assign w_cmd.value = i_data_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_prev_entry;
        logic   w_prev_valid;
        logic   w_prev_keep;
        t_entry w_next_entry;
        logic   w_next_valid;

        if (g == 0) begin : g_head
            // The head has no left neighbor: a non-keeping head takes the new value.
            assign w_prev_entry = i_data_value;
            assign w_prev_valid = 1'b1;
            assign w_prev_keep  = 1'b1;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_keep  = w_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_entry = w_entry[g];
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_entry = w_entry[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_entry (w_prev_entry),
            .i_prev_valid (w_prev_valid),
            .i_prev_keep  (w_prev_keep),
            .i_next_entry (w_next_entry),
            .i_next_valid (w_next_valid),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_keep       (w_keep[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Hold the result until the downstream side takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_xfer) begin
            r_popped       <= w_cmd.pop ? w_entry[0] : '0;
            r_empty_pop    <= (i_opcode == OP_POP) && w_empty;
            r_push_dropped <= (i_opcode == OP_PUSH) && w_full;
            r_entry_count  <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_entry_count  = r_entry_count;
    assign o_empty_pop    = r_empty_pop;
    assign o_push_dropped = r_push_dropped;

    // The count always equals the number of occupied cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'($countones(w_valid)) == r_count)
        else $error("entry count differs from occupied cells");

    // Occupied cells form a contiguous run starting at the head.
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + CAPACITY'(1)) & w_valid) == '0)
        else $error("occupied cells are not packed at the head");

    // The two head cells stay in descending order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_entry[0] >= w_entry[1]))
        else $error("head cells out of order");

    // A rejected operation leaves the count unchanged.
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && !w_cmd.push && !w_cmd.pop) |=> $stable(r_count))
        else $error("rejected operation changed the count");

endmodule
`default_nettype wire

### bench/tb_sorted_insert_priority_queue.sv
// Self-checking bench for the sorted-insert priority queue: predictor, stimulus and checks.
`timescale 1ns / 100ps
module tb_sorted_insert_priority_queue;
    import spq_pkg::*;

    // Give up well past the slowest legal run: about 1250 transfers, each with a
    // random sender gap and receiver stall, plus the long hold-off.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX    = 10;

    // One result as the block reports it.
    typedef struct packed {
        t_entry             popped;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               dropped;
    } t_queue_reply;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                i_opcode       = OP_PUSH;
    logic signed [31:0]  i_data_value   = '0;
    logic                i_out_ready    = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic signed [31:0]  o_popped_value;
    logic [4:0]          o_entry_count;
    logic                o_empty_pop;
    logic                o_push_dropped;

    // Shadow copy of the queue contents, ascending, and the replies still owed.
    t_entry       shadow_entries[$];
    t_queue_reply replies_due[$];

    // Knobs for the stimulus and the receiver; stall_left is the receiver's own.
    bit idle_on;
    int hold_left;
    int stall_left;

    int mismatches;
    int cycle_count;
    int push_total, pop_total, drop_total, empty_total, peak_depth, replies_seen;

    sorted_insert_priority_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_data_value  (i_data_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_popped_value(o_popped_value),
        .o_entry_count (o_entry_count),
        .o_empty_pop   (o_empty_pop),
        .o_push_dropped(o_push_dropped)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the shadow queue and return the reply it must produce.
    function automatic t_queue_reply shadow_queue_op(logic op, t_entry value);
        t_queue_reply reply;
        int           pos;
        reply = '0;
        if (op == OP_PUSH) begin
            push_total++;
            if (shadow_entries.size() >= CAPACITY) begin
                reply.dropped = 1'b1;
                drop_total++;
            end else begin
                // Land ahead of stored equals: stop at the first entry not smaller.
                pos = 0;
                while (pos < shadow_entries.size() && shadow_entries[pos] < value)
                    pos++;
                shadow_entries.insert(pos, value);
            end
        end else begin
            pop_total++;
            if (shadow_entries.size() == 0) begin
                reply.empty = 1'b1;
                empty_total++;
            end else begin
                reply.popped = shadow_entries.pop_back();
            end
        end
        if (shadow_entries.size() > peak_depth)
            peak_depth = shadow_entries.size();
        // Count wraps modulo 32 on the port.
        reply.count = COUNT_W'(shadow_entries.size());
        return reply;
    endfunction

    // Small clustered values to force duplicates, some extremes, the rest anything.
    function automatic t_entry pick_value();
        t_entry value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: value = t_entry'(int'($urandom_range(0, 8)) - 4);
            4: begin
                case ($urandom_range(0, 3))
                    0:       value = 32'sh7FFF_FFFF;
                    1:       value = 32'sh8000_0000;
                    2:       value = 32'sh0000_0000;
                    default: value = 32'shFFFF_FFFF;
                endcase
            end
            default: value = t_entry'($urandom);
        endcase
        return value;
    endfunction

    // Offer one item and hold it until the transfer; record the reply it owes.
    task automatic send_op(logic op, t_entry value);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_data_value <= value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        replies_due.push_back(shadow_queue_op(op, value));
    endtask

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch %0d at cycle %0d: %s expected %0h got %0h",
                     mismatches, cycle_count, what, want, got);
    endtask

    // Receiver: drain results, with random stall bursts and the long hold-off
    // counted down here so the sender keeps pushing against a full pipeline.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Checker: compare every result transfer with the oldest reply owed.
    always @(posedge i_clk) begin
        t_queue_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
                flag_mismatch("unexpected result, popped_value", '0, o_popped_value);
            end else begin
                want = replies_due.pop_front();
                if (o_popped_value !== want.popped)
                    flag_mismatch("popped_value", want.popped, o_popped_value);
                if (o_entry_count !== want.count)
                    flag_mismatch("entry_count", 32'(want.count), 32'(o_entry_count));
                if (o_empty_pop !== want.empty)
                    flag_mismatch("empty_pop", 32'(want.empty), 32'(o_empty_pop));
                if (o_push_dropped !== want.dropped)
                    flag_mismatch("push_dropped", 32'(want.dropped), 32'(o_push_dropped));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, replies_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Pop on an empty queue right after reset, then the value extremes,
    // equal values, and a drain that runs one pop past empty.
    task automatic test_extremes_and_empty();
        send_op(OP_POP, 32'sh1234_5678);
        send_op(OP_PUSH, 32'sh7FFF_FFFF);
        send_op(OP_PUSH, 32'sh8000_0000);
        send_op(OP_PUSH, 32'sh0000_0000);
        send_op(OP_PUSH, 32'shFFFF_FFFF);
        send_op(OP_PUSH, 32'sh0000_0001);
        send_op(OP_PUSH, 32'sh0000_0000);
        send_op(OP_PUSH, 32'sh7FFF_FFFF);
        send_op(OP_PUSH, 32'sh8000_0000);
        repeat (9) send_op(OP_POP, 32'shFFFF_FFFF);
    endtask

    // Fill past capacity so pushes drop, then drain past empty.
    task automatic test_fill_and_drain();
        repeat (CAPACITY + 3) send_op(OP_PUSH, pick_value());
        repeat (CAPACITY + 2) send_op(OP_POP, t_entry'($urandom));
    endtask

    // Hold the result side off for a long stretch while pushes keep coming,
    // so the output register fills and the input side stalls.
    task automatic test_output_holdoff();
        hold_left = 80;
        repeat (24) send_op(OP_PUSH, pick_value());
        repeat (6) send_op(OP_POP, t_entry'($urandom));
    endtask

    // Random phases biased toward push or pop so the depth sweeps the whole
    // range, hitting full and empty repeatedly with random content.
    task automatic test_random_mix(int item_total);
        int push_pct;
        int phase_left;
        phase_left = 0;
        push_pct   = 50;
        repeat (item_total) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            phase_left--;
            if ($urandom_range(1, 100) <= push_pct)
                send_op(OP_PUSH, pick_value());
            else
                send_op(OP_POP, t_entry'($urandom));
        end
    endtask

    initial begin
        idle_on      = 1'b1;
        hold_left    = 0;
        stall_left   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        push_total   = 0;
        pop_total    = 0;
        drop_total   = 0;
        empty_total  = 0;
        peak_depth   = 0;
        replies_seen = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes_and_empty();
        test_fill_and_drain();
        test_output_holdoff();
        test_random_mix(1000);
        // Back-to-back traffic on both sides to close out the run.
        idle_on = 1'b0;
        test_random_mix(150);
        i_in_valid <= 1'b0;

        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d pushes (%0d dropped on a full queue) and %0d pops (%0d on empty)",
                 push_total, drop_total, pop_total, empty_total);
        $display("checked %0d results, peak depth %0d of %0d, %0d mismatches",
                 replies_seen, peak_depth, CAPACITY, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
